// File: design/lnec_pkg.sv
// Package for the noise envelope channel: operation codes, register indexes,
// bus field widths and the period and length lookup tables.
// No dependencies; used by lfsr_noise_envelope_channel_unit.
package lnec_pkg;

  // Operation carried by each input item.
  typedef enum logic [2:0] {
    OP_REG_WRITE   = 3'd0,
    OP_TIMER_TICK  = 3'd1,
    OP_ENV_CLOCK   = 3'd2,
    OP_LEN_CLOCK   = 3'd3,
    OP_ENABLE      = 3'd4
  } op_t;

  // Register numbers for register writes.
  localparam logic [1:0] REG_CONTROL = 2'd0;
  localparam logic [1:0] REG_UNUSED  = 2'd1;
  localparam logic [1:0] REG_MODE    = 2'd2;
  localparam logic [1:0] REG_LENGTH  = 2'd3;

  localparam int OpW        = 3;
  localparam int InDataW    = 16;
  localparam int OutDataW   = 8;
  localparam int LfsrW      = 15;
  localparam int TimerW     = 12;

  localparam logic [3:0]        EnvDecayFull = 4'd15;
  localparam logic [LfsrW-1:0]  LfsrReset    = 15'd1;
  localparam logic [TimerW-1:0] TimerReloadReset = 12'd3;

  // Timer period table, returned already less one for use as a reload value.
  function automatic logic [TimerW-1:0] period_reload(input logic [3:0] idx);
    logic [TimerW-1:0] p;
    unique case (idx)
      4'd0:  p = 12'd4;
      4'd1:  p = 12'd8;
      4'd2:  p = 12'd16;
      4'd3:  p = 12'd32;
      4'd4:  p = 12'd64;
      4'd5:  p = 12'd96;
      4'd6:  p = 12'd128;
      4'd7:  p = 12'd160;
      4'd8:  p = 12'd202;
      4'd9:  p = 12'd254;
      4'd10: p = 12'd380;
      4'd11: p = 12'd508;
      4'd12: p = 12'd762;
      4'd13: p = 12'd1016;
      4'd14: p = 12'd2034;
      default: p = 12'd4068;
    endcase
    return p - 12'd1;
  endfunction

  // Length counter load table.
  function automatic logic [7:0] length_load(input logic [4:0] idx);
    logic [7:0] v;
    unique case (idx)
      5'd0:  v = 8'h0A;  5'd1:  v = 8'hFE;  5'd2:  v = 8'h14;  5'd3:  v = 8'h02;
      5'd4:  v = 8'h28;  5'd5:  v = 8'h04;  5'd6:  v = 8'h50;  5'd7:  v = 8'h06;
      5'd8:  v = 8'hA0;  5'd9:  v = 8'h08;  5'd10: v = 8'h3C;  5'd11: v = 8'h0A;
      5'd12: v = 8'h0E;  5'd13: v = 8'h0C;  5'd14: v = 8'h1A;  5'd15: v = 8'h0E;
      5'd16: v = 8'h0C;  5'd17: v = 8'h10;  5'd18: v = 8'h18;  5'd19: v = 8'h12;
      5'd20: v = 8'h30;  5'd21: v = 8'h14;  5'd22: v = 8'h60;  5'd23: v = 8'h16;
      5'd24: v = 8'hC0;  5'd25: v = 8'h18;  5'd26: v = 8'h48;  5'd27: v = 8'h1A;
      5'd28: v = 8'h10;  5'd29: v = 8'h1C;  5'd30: v = 8'h20;  default: v = 8'h1E;
    endcase
    return v;
  endfunction

endpackage

// File: design/lfsr_noise_envelope_channel_unit.sv
// Noise channel with 15-bit LFSR, programmable timer, envelope and length counter.
// Depends on lnec_pkg for operation codes and lookup tables.
//
//  Channel | Direction | Signals                          | Item
//  --------+-----------+----------------------------------+-------------------------------
//  s_*     | in        | s_tvalid s_tready s_tdata s_tuser| one operation (write/tick/...)
//  m_*     | out       | m_tvalid m_tready m_tdata        | sample and length status
//
// Each accepted item updates the channel state in the same cycle and its result
// appears in the output register on the next cycle; one item per cycle is taken unless stalled.
// The single output register sets the pace: s_tready is high whenever that
// register is empty or is being drained, so a stalled output holds the input.
// rst is synchronous, active high, and returns all state but the m_tdata payload to power-on values.
module lfsr_noise_envelope_channel_unit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // [1:0] reg_index, [9:2] write_data, [10] enable_value, [15:11] zero
  input  logic [lnec_pkg::InDataW-1:0]   s_tdata,
  // [2:0] op
  input  logic [lnec_pkg::OpW-1:0]       s_tuser,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // [3:0] sample, [4] length_active, [7:5] zero
  output logic [lnec_pkg::OutDataW-1:0]  m_tdata
);
  import lnec_pkg::*;

  // Channel state.
  logic [LfsrW-1:0]  lfsr, lfsr_next;
  logic [TimerW-1:0] timer_count, timer_count_next;
  logic [TimerW-1:0] timer_reload, timer_reload_next;
  logic              short_mode, short_mode_next;
  logic              halt_loop, halt_loop_next;
  logic              constant_flag, constant_flag_next;
  logic [3:0]        env_period, env_period_next;
  logic [3:0]        env_divider, env_divider_next;
  logic [3:0]        env_decay, env_decay_next;
  logic              env_start, env_start_next;
  logic [3:0]        volume, volume_next;
  logic [7:0]        length_count, length_count_next;
  logic              length_enabled, length_enabled_next;

  logic [1:0] reg_index;
  logic [7:0] write_data;
  logic       enable_value;
  logic       accept;
  logic       feedback;
  logic [3:0] sample_next;

  assign reg_index    = s_tdata[1:0];
  assign write_data   = s_tdata[9:2];
  assign enable_value = s_tdata[10];

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  // Feedback bit taps bit 1 in long mode and bit 6 in short mode.
  assign feedback = lfsr[0] ^ (short_mode ? lfsr[6] : lfsr[1]);

  // Next channel state for the operation of the current input item.
  always_comb begin
    lfsr_next           = lfsr;
    timer_count_next    = timer_count;
    timer_reload_next   = timer_reload;
    short_mode_next     = short_mode;
    halt_loop_next      = halt_loop;
    constant_flag_next  = constant_flag;
    env_period_next     = env_period;
    env_divider_next    = env_divider;
    env_decay_next      = env_decay;
    env_start_next      = env_start;
    volume_next         = volume;
    length_count_next   = length_count;
    length_enabled_next = length_enabled;

    unique case (op_t'(s_tuser))
      OP_REG_WRITE: begin
        unique case (reg_index)
          REG_CONTROL: begin
            halt_loop_next     = write_data[5];
            constant_flag_next = write_data[4];
            env_period_next    = write_data[3:0];
            volume_next        = write_data[4] ? write_data[3:0] : env_decay;
          end
          REG_MODE: begin
            short_mode_next   = write_data[7];
            timer_reload_next = period_reload(write_data[3:0]);
          end
          REG_LENGTH: begin
            env_start_next = 1'b1;
            if (length_enabled) begin
              length_count_next = length_load(write_data[7:3]);
            end
          end
          REG_UNUSED: begin
          end
        endcase
      end
      OP_TIMER_TICK: begin
        if (timer_count == '0) begin
          lfsr_next        = {feedback, lfsr[LfsrW-1:1]};
          timer_count_next = timer_reload;
        end else begin
          timer_count_next = timer_count - 1'b1;
        end
      end
      OP_ENV_CLOCK: begin
        if (env_start) begin
          env_start_next   = 1'b0;
          env_decay_next   = EnvDecayFull;
          env_divider_next = env_period;
        end else if (env_divider == 4'd0) begin
          env_divider_next = env_period;
          if (env_decay != 4'd0) begin
            env_decay_next = env_decay - 4'd1;
          end else if (halt_loop) begin
            env_decay_next = EnvDecayFull;
          end
        end else begin
          env_divider_next = env_divider - 4'd1;
        end
        volume_next = constant_flag ? env_period : env_decay_next;
      end
      OP_LEN_CLOCK: begin
        if (!halt_loop && length_count != 8'd0) begin
          length_count_next = length_count - 8'd1;
        end
      end
      OP_ENABLE: begin
        length_enabled_next = enable_value;
        if (!enable_value) begin
          length_count_next = 8'd0;
        end
      end
      default: begin
      end
    endcase
  end

  // Output level after the operation: silenced by the LFSR or an empty length.
  assign sample_next = (length_count_next != 8'd0 && !lfsr_next[0]) ? volume_next : 4'd0;

  // State registers, updated only on an accepted item.
  always_ff @(posedge clk) begin
    if (rst) begin
      lfsr           <= LfsrReset;
      timer_count    <= '0;
      timer_reload   <= TimerReloadReset;
      short_mode     <= 1'b0;
      halt_loop      <= 1'b0;
      constant_flag  <= 1'b0;
      env_period     <= 4'd0;
      env_divider    <= 4'd0;
      env_decay      <= 4'd0;
      env_start      <= 1'b0;
      volume         <= 4'd0;
      length_count   <= 8'd0;
      length_enabled <= 1'b0;
    end else if (accept) begin
      lfsr           <= lfsr_next;
      timer_count    <= timer_count_next;
      timer_reload   <= timer_reload_next;
      short_mode     <= short_mode_next;
      halt_loop      <= halt_loop_next;
      constant_flag  <= constant_flag_next;
      env_period     <= env_period_next;
      env_divider    <= env_divider_next;
      env_decay      <= env_decay_next;
      env_start      <= env_start_next;
      volume         <= volume_next;
      length_count   <= length_count_next;
      length_enabled <= length_enabled_next;
    end
  end

  // Output register: valid flag under reset, payload loaded on accept.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_tdata <= {3'b000, (length_count_next != 8'd0), sample_next};
    end
  end

  // The LFSR can never fall into the all-zero lockup state.
  a_lfsr_nonzero: assert property (@(posedge clk) disable iff (rst)
    lfsr != '0) else $error("LFSR reached zero");

  // A nonzero length count is only possible while the length is enabled.
  a_length_needs_enable: assert property (@(posedge clk) disable iff (rst)
    length_count != 8'd0 |-> length_enabled) else $error("length loaded while disabled");

  // In constant-volume mode the level always follows the envelope period.
  a_constant_volume: assert property (@(posedge clk) disable iff (rst)
    constant_flag |-> volume == env_period) else $error("constant volume mismatch");

  // An audible sample always comes with an active length status.
  a_sample_needs_length: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[3:0] != 4'd0 |-> m_tdata[4]) else $error("sample without length");

  // Every accepted item leaves a result in the output register.
  a_accept_gives_result: assert property (@(posedge clk) disable iff (rst)
    accept |=> m_tvalid) else $error("accepted item produced no result");

endmodule

// File: bench/lfsr_noise_envelope_channel_unit_tb.sv
// Self-checking bench for the noise channel: directed and random operation items,
// a cycle-free behavioral model of the channel, and random stalls on both streams.
// Depends on lnec_pkg and lfsr_noise_envelope_channel_unit.
module lfsr_noise_envelope_channel_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lnec_pkg::*;

  // Op codes above OP_ENABLE are reserved; the block must leave state untouched.
  localparam logic [2:0] OpReservedLo = 3'd5;
  localparam logic [2:0] OpReservedHi = 3'd7;
  localparam int RandomItems = 1850;
  localparam int IdleLimit   = 2000;
  localparam int DrainCycles = 8;

  typedef struct packed {
    logic [2:0] op;
    logic [1:0] reg_index;
    logic [7:0] write_data;
    logic       enable_value;
  } chan_op_t;

  typedef struct packed {
    logic [3:0] sample;
    logic       length_active;
  } level_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [InDataW-1:0]    s_tdata = '0;
  logic [OpW-1:0]        s_tuser = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OutDataW-1:0]   m_tdata;

  lfsr_noise_envelope_channel_unit u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Timer periods and length loads as the channel defines them.
  logic [11:0] period_steps [16] = '{
    12'd4, 12'd8, 12'd16, 12'd32, 12'd64, 12'd96, 12'd128, 12'd160,
    12'd202, 12'd254, 12'd380, 12'd508, 12'd762, 12'd1016, 12'd2034, 12'd4068
  };
  logic [7:0] length_steps [32] = '{
    8'h0A, 8'hFE, 8'h14, 8'h02, 8'h28, 8'h04, 8'h50, 8'h06,
    8'hA0, 8'h08, 8'h3C, 8'h0A, 8'h0E, 8'h0C, 8'h1A, 8'h0E,
    8'h0C, 8'h10, 8'h18, 8'h12, 8'h30, 8'h14, 8'h60, 8'h16,
    8'hC0, 8'h18, 8'h48, 8'h1A, 8'h10, 8'h1C, 8'h20, 8'h1E
  };

  // Behavioral copy of the channel state.
  logic [14:0] noise_lfsr;
  logic [11:0] timer_left;
  logic [11:0] timer_period;
  logic        short_taps;
  logic        halt_or_loop;
  logic        fixed_volume;
  logic [3:0]  env_rate;
  logic [3:0]  env_div;
  logic [3:0]  env_level;
  logic        env_restart;
  logic [3:0]  out_volume;
  logic [7:0]  length_left;
  logic        length_on;

  chan_op_t ops_to_send [$];
  level_t   levels_due [$];
  chan_op_t op_on_bus;
  logic     in_taken  = 1'b0;
  logic     out_taken = 1'b0;
  int       send_gap  = 0;
  int       sink_wait = 0;
  logic     send_burst = 1'b0;
  logic     sink_burst = 1'b0;
  int       idle_cycles = 0;
  int       error_count = 0;
  int       levels_checked = 0;
  int       audible_levels = 0;
  int       op_seen [8];

  // Apply one operation to the channel state and return the level it leaves.
  task automatic apply_channel_op(input chan_op_t it, output level_t lvl);
    logic tap;
    case (it.op)
      OP_REG_WRITE: begin
        case (it.reg_index)
          REG_CONTROL: begin
            halt_or_loop = it.write_data[5];
            fixed_volume = it.write_data[4];
            env_rate     = it.write_data[3:0];
            out_volume   = fixed_volume ? env_rate : env_level;
          end
          REG_MODE: begin
            short_taps   = it.write_data[7];
            timer_period = period_steps[it.write_data[3:0]] - 12'd1;
          end
          REG_LENGTH: begin
            env_restart = 1'b1;
            if (length_on) length_left = length_steps[it.write_data[7:3]];
          end
          default: ;
        endcase
      end
      OP_TIMER_TICK: begin
        if (timer_left == '0) begin
          tap        = short_taps ? noise_lfsr[6] : noise_lfsr[1];
          noise_lfsr = {noise_lfsr[0] ^ tap, noise_lfsr[14:1]};
          timer_left = timer_period;
        end else begin
          timer_left = timer_left - 12'd1;
        end
      end
      OP_ENV_CLOCK: begin
        if (env_restart) begin
          env_restart = 1'b0;
          env_level   = EnvDecayFull;
          env_div     = env_rate;
        end else if (env_div == '0) begin
          env_div = env_rate;
          if (env_level != '0) env_level = env_level - 4'd1;
          else if (halt_or_loop) env_level = EnvDecayFull;
        end else begin
          env_div = env_div - 4'd1;
        end
        out_volume = fixed_volume ? env_rate : env_level;
      end
      OP_LEN_CLOCK: begin
        if (!halt_or_loop && length_left != '0) length_left = length_left - 8'd1;
      end
      OP_ENABLE: begin
        length_on = it.enable_value;
        if (!length_on) length_left = '0;
      end
      default: ;
    endcase
    lvl.length_active = (length_left != '0);
    lvl.sample        = (lvl.length_active && !noise_lfsr[0]) ? out_volume : 4'd0;
  endtask

  function automatic chan_op_t make_op(logic [2:0] op, logic [1:0] idx, logic [7:0] data,
                                       logic en);
    chan_op_t it;
    it.op           = op;
    it.reg_index    = idx;
    it.write_data   = data;
    it.enable_value = en;
    return it;
  endfunction

  // Mostly clocks and ticks, a fair share of register writes with short timer
  // periods favored so the shift register moves, and a little noise.
  function automatic chan_op_t random_channel_op();
    chan_op_t it;
    int pick;
    it.reg_index    = 2'($urandom_range(0, 3));
    it.write_data   = 8'($urandom_range(0, 255));
    it.enable_value = ($urandom_range(0, 9) != 0);
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      it.op = OP_TIMER_TICK;
    end else if (pick < 60) begin
      it.op = OP_ENV_CLOCK;
    end else if (pick < 70) begin
      it.op = OP_LEN_CLOCK;
    end else if (pick < 90) begin
      it.op = OP_REG_WRITE;
      if (it.reg_index == REG_MODE && $urandom_range(0, 7) != 0)
        it.write_data[3:0] = 4'($urandom_range(0, 3));
    end else if (pick < 95) begin
      it.op = OP_ENABLE;
    end else begin
      it.op = 3'($urandom_range(OpReservedLo, OpReservedHi));
    end
    return it;
  endfunction

  function automatic int draw_wait(inout logic burst);
    if ($urandom_range(0, 39) == 0) burst = !burst;
    return burst ? 0 : $urandom_range(0, 4);
  endfunction

  // Source side: present queued items, with a random gap after each one.
  always @(negedge clk) begin : driver
    logic valid_next;
    valid_next = s_tvalid;
    if (!rst) begin
      if (s_tvalid && in_taken) begin
        valid_next = 1'b0;
        send_gap   = draw_wait(send_burst);
      end
      if (!valid_next) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (ops_to_send.size() != 0) begin
          op_on_bus = ops_to_send.pop_front();
          s_tdata <= InDataW'({op_on_bus.enable_value, op_on_bus.write_data,
                               op_on_bus.reg_index});
          s_tuser <= op_on_bus.op;
          valid_next = 1'b1;
        end
      end
    end
    s_tvalid <= valid_next;
  end

  // Sink side: hold m_tready low for a random wait after each accepted result.
  always @(negedge clk) begin : sink
    if (out_taken) sink_wait = draw_wait(sink_burst);
    if (sink_wait > 0) begin
      sink_wait--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Check results against the oldest expected level, then predict new items.
  always @(posedge clk) begin : monitor
    level_t want;
    level_t got;
    in_taken  = !rst && s_tvalid && s_tready;
    out_taken = !rst && m_tvalid && m_tready;
    if (out_taken) begin
      got.sample        = m_tdata[3:0];
      got.length_active = m_tdata[4];
      levels_checked++;
      if (got.sample != 4'd0) audible_levels++;
      if (levels_due.size() == 0) begin
        $error("unexpected result: sample %0d length_active %0d",
               got.sample, got.length_active);
        error_count++;
      end else begin
        want = levels_due.pop_front();
        if (got.sample != want.sample) begin
          $error("sample mismatch: expected %0d, actual %0d", want.sample, got.sample);
          error_count++;
        end
        if (got.length_active != want.length_active) begin
          $error("length_active mismatch: expected %0d, actual %0d",
                 want.length_active, got.length_active);
          error_count++;
        end
      end
    end
    if (in_taken) begin
      apply_channel_op(op_on_bus, want);
      levels_due.push_back(want);
      op_seen[op_on_bus.op]++;
    end
    // Watchdog on cycles where neither stream moves.
    if (in_taken || out_taken || rst) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IdleLimit) begin
      $display("Timeout: no item moved for %0d cycles", IdleLimit);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    foreach (op_seen[i]) op_seen[i] = 0;
    noise_lfsr   = LfsrReset;
    timer_left   = '0;
    timer_period = TimerReloadReset;
    short_taps   = 1'b0;
    halt_or_loop = 1'b0;
    fixed_volume = 1'b0;
    env_rate     = '0;
    env_div      = '0;
    env_level    = '0;
    env_restart  = 1'b0;
    out_volume   = '0;
    length_left  = '0;
    length_on    = 1'b0;

    // Directed part: table extremes, every op, unused register, reserved ops,
    // halted length clocks, and length loads with the channel disabled.
    ops_to_send.push_back(make_op(OP_TIMER_TICK, 2'd3, 8'hFF, 1'b1));
    ops_to_send.push_back(make_op(OP_ENABLE, 2'd0, 8'h00, 1'b1));
    ops_to_send.push_back(make_op(OP_REG_WRITE, REG_LENGTH, 8'h08, 1'b0));
    ops_to_send.push_back(make_op(OP_REG_WRITE, REG_CONTROL, 8'h0F, 1'b0));
    ops_to_send.push_back(make_op(OP_ENV_CLOCK, 2'd0, 8'h00, 1'b0));
    ops_to_send.push_back(make_op(OP_REG_WRITE, REG_CONTROL, 8'h1F, 1'b0));
    ops_to_send.push_back(make_op(OP_REG_WRITE, REG_MODE, 8'h80, 1'b0));
    repeat (5) ops_to_send.push_back(make_op(OP_TIMER_TICK, 2'd0, 8'h00, 1'b0));
    ops_to_send.push_back(make_op(OP_REG_WRITE, REG_UNUSED, 8'hFF, 1'b1));
    ops_to_send.push_back(make_op(OP_LEN_CLOCK, 2'd0, 8'h00, 1'b0));
    ops_to_send.push_back(make_op(OP_REG_WRITE, REG_CONTROL, 8'hE0, 1'b0));
    ops_to_send.push_back(make_op(OP_LEN_CLOCK, 2'd2, 8'hFF, 1'b1));
    repeat (2) ops_to_send.push_back(make_op(OP_ENV_CLOCK, 2'd1, 8'hAA, 1'b1));
    for (int k = OpReservedLo; k <= OpReservedHi; k++)
      ops_to_send.push_back(make_op(3'(k), REG_LENGTH, 8'hFF, 1'b1));
    ops_to_send.push_back(make_op(OP_REG_WRITE, REG_MODE, 8'h0F, 1'b0));
    ops_to_send.push_back(make_op(OP_ENABLE, 2'd3, 8'hFF, 1'b0));
    ops_to_send.push_back(make_op(OP_REG_WRITE, REG_LENGTH, 8'hF8, 1'b0));
    ops_to_send.push_back(make_op(OP_ENABLE, 2'd0, 8'h00, 1'b1));
    ops_to_send.push_back(make_op(OP_REG_WRITE, REG_LENGTH, 8'hF8, 1'b0));
    ops_to_send.push_back(make_op(OP_REG_WRITE, REG_MODE, 8'h00, 1'b0));

    repeat (RandomItems) ops_to_send.push_back(random_channel_op());

    repeat (12) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // Wait for all items to go out and every expected level to come back.
    while (ops_to_send.size() != 0 || s_tvalid || levels_due.size() != 0)
      @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    $display("Items: %0d writes, %0d ticks, %0d envelope, %0d length, %0d enable, %0d reserved",
             op_seen[OP_REG_WRITE], op_seen[OP_TIMER_TICK], op_seen[OP_ENV_CLOCK],
             op_seen[OP_LEN_CLOCK], op_seen[OP_ENABLE],
             op_seen[5] + op_seen[6] + op_seen[7]);
    $display("Results checked: %0d, of which %0d with a nonzero sample",
             levels_checked, audible_levels);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
